>>> rtl/tam_pkg.sv
// ----------------------------------------------------------------------------
// tam_pkg
// Types and constants shared by the thermal alarm monitor: payload structs,
// configuration register map, message codes and fixed time intervals.
// ----------------------------------------------------------------------------
package tam_pkg;

    localparam int unsigned RECHECK_MS     = 1000;
    localparam int unsigned BUZZ_PERIOD_MS = 3000;
    localparam int unsigned BUZZ_FIRST_MS  = 4000;

    localparam int unsigned CFG_IDX_BITS = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_HOT_LIMIT      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COLD_LIMIT     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TEMP_OFFSET    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INJURY_HOLD_MS = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_SPAN    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RISE_LIMIT     = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_DANGER_CNT = 3'd6;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_POLL   = 1'b1;

    localparam logic [1:0] MSG_NONE    = 2'd0;
    localparam logic [1:0] MSG_DANGER  = 2'd1;
    localparam logic [1:0] MSG_COLD    = 2'd2;
    localparam logic [1:0] MSG_CLEARED = 2'd3;

    typedef struct packed {
        logic               command;
        logic [31:0]        now_ms;
        logic signed [15:0] temperature;
        logic               button;
    } t_item;

    typedef struct packed {
        logic       fuse_off;
        logic [1:0] message;
        logic       buzz;
        logic       in_danger;
        logic       hot_event;
        logic       cold_event;
        logic       rate_event;
    } t_result;

    typedef struct packed {
        logic [CFG_IDX_BITS-1:0] index;
        logic [31:0]             value;
    } t_cfg_wr;

    typedef struct packed {
        logic signed [15:0] hot_limit;
        logic signed [15:0] cold_limit;
        logic signed [12:0] temp_offset;
        logic [31:0]        injury_hold_ms;
        logic [7:0]         sample_span;
        logic [15:0]        rise_limit;
        logic [7:0]         max_danger_count;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        hot_limit:        16'sd3900,
        cold_limit:       16'sd3200,
        temp_offset:      13'sd0,
        injury_hold_ms:   32'd60000,
        sample_span:      8'd10,
        rise_limit:       16'd100,
        max_danger_count: 8'd3
    };

endpackage

>>> rtl/tam_stream_if.sv
// ----------------------------------------------------------------------------
// tam_stream_if
// Valid/ready channel carrying one payload struct per transfer.
// ----------------------------------------------------------------------------
interface tam_stream_if #(
    parameter type t_payload = logic
) ();

    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

>>> rtl/tam_cfg_regs.sv
// ----------------------------------------------------------------------------
// tam_cfg_regs
// Configuration register file; takes one register write per transfer.
// ----------------------------------------------------------------------------
module tam_cfg_regs
    import tam_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    tam_stream_if.sink  i_cfg,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.data.index)
                CFG_HOT_LIMIT:      r_cfg.hot_limit        <= i_cfg.data.value[15:0];
                CFG_COLD_LIMIT:     r_cfg.cold_limit       <= i_cfg.data.value[15:0];
                CFG_TEMP_OFFSET:    r_cfg.temp_offset      <= i_cfg.data.value[12:0];
                CFG_INJURY_HOLD_MS: r_cfg.injury_hold_ms   <= i_cfg.data.value;
                CFG_SAMPLE_SPAN:    r_cfg.sample_span      <= i_cfg.data.value[7:0];
                CFG_RISE_LIMIT:     r_cfg.rise_limit       <= i_cfg.data.value[15:0];
                CFG_MAX_DANGER_CNT: r_cfg.max_danger_count <= i_cfg.data.value[7:0];
                default: begin
                end
            endcase
        end
    end

endmodule

>>> rtl/tam_engine.sv
// ----------------------------------------------------------------------------
// tam_engine
// Monitor state and the single-pass step logic: limit checks with recheck
// deadlines, rise-rate measurement by cross multiplication, alarm and buzzer.
// ----------------------------------------------------------------------------
module tam_engine
    import tam_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_advance,
    input  t_item   i_item,
    output t_result o_result
);

    logic                 r_danger;
    logic [TIME_BITS-1:0] r_hot_dl;
    logic [TIME_BITS-1:0] r_cold_dl;
    logic [TIME_BITS-1:0] r_buzz_dl;
    logic [7:0]           r_span_tick;
    logic [TIME_BITS-1:0] r_start_time;
    logic signed [15:0]   r_start_temp;
    logic [7:0]           r_rise_cnt;

    logic                 n_danger;
    logic [TIME_BITS-1:0] n_hot_dl;
    logic [TIME_BITS-1:0] n_cold_dl;
    logic [TIME_BITS-1:0] n_buzz_dl;
    logic [7:0]           n_span_tick;
    logic [TIME_BITS-1:0] n_start_time;
    logic signed [15:0]   n_start_temp;
    logic [7:0]           n_rise_cnt;

    logic                 w_sample;
    logic [TIME_BITS-1:0] w_now;
    logic [TIME_BITS-1:0] w_now_hold;
    logic [TIME_BITS-1:0] w_now_recheck;
    logic [TIME_BITS-1:0] w_now_buzz;
    logic [TIME_BITS-1:0] w_hot_age;
    logic [TIME_BITS-1:0] w_cold_age;
    logic [TIME_BITS-1:0] w_buzz_age;
    logic [TIME_BITS-1:0] w_gap;
    logic [31:0]          w_gap32;
    logic                 w_gap_big;
    logic signed [16:0]   w_raw;
    logic signed [16:0]   w_temp;
    logic signed [16:0]   w_hot_lim;
    logic signed [16:0]   w_cold_lim;
    logic signed [16:0]   w_dtemp;
    logic [25:0]          w_rise_lhs;
    logic [47:0]          w_rise_rhs;
    logic                 w_fast;
    logic                 w_hot_exp;
    logic                 w_cold_exp;
    logic                 w_buzz_exp;
    logic                 w_hot_ev;
    logic                 w_cold_ev;
    logic                 w_rate_ev;
    logic                 w_clear;
    logic [7:0]           w_tick;
    logic                 w_measure;
    logic [7:0]           w_cnt_inc;

    assign w_sample      = (i_item.command == CMD_SAMPLE);
    assign w_now         = TIME_BITS'(i_item.now_ms);
    assign w_now_hold    = w_now + TIME_BITS'(i_cfg.injury_hold_ms);
    assign w_now_recheck = w_now + TIME_BITS'(RECHECK_MS);
    assign w_now_buzz    = w_now + TIME_BITS'(BUZZ_PERIOD_MS);
    assign w_hot_age     = w_now - r_hot_dl;
    assign w_cold_age    = w_now - r_cold_dl;
    assign w_buzz_age    = w_now - r_buzz_dl;
    assign w_gap         = w_now - r_start_time;
    assign w_gap32       = 32'(w_gap);

    generate
        if (TIME_BITS > 32) begin : g_wide_time
            assign w_gap_big = |w_gap[TIME_BITS-1:32];
        end else begin : g_narrow_time
            assign w_gap_big = 1'b0;
        end
    endgenerate

    assign w_raw      = {i_item.temperature[15], i_item.temperature};
    assign w_temp     = w_raw + {{4{i_cfg.temp_offset[12]}}, i_cfg.temp_offset};
    assign w_hot_lim  = {i_cfg.hot_limit[15], i_cfg.hot_limit};
    assign w_cold_lim = {i_cfg.cold_limit[15], i_cfg.cold_limit};

    // cold check sees the cold deadline already pushed out by a hot alarm
    assign w_hot_exp  = !w_hot_age[TIME_BITS-1];
    assign w_hot_ev   = w_sample && w_hot_exp && (w_temp > w_hot_lim);
    assign w_cold_exp = !w_cold_age[TIME_BITS-1] && !w_hot_ev;
    assign w_cold_ev  = w_sample && w_cold_exp && (w_temp < w_cold_lim);
    assign w_buzz_exp = !w_buzz_age[TIME_BITS-1];

    // rise rate: dtemp * 1000 >= rise_limit * gap
    assign w_dtemp    = w_raw - {r_start_temp[15], r_start_temp};
    assign w_rise_lhs = 26'(w_dtemp[15:0]) * 26'd1000;
    assign w_rise_rhs = 48'(i_cfg.rise_limit) * 48'(w_gap32);
    assign w_fast     = (w_gap != '0) && !w_dtemp[16]
                        && ((i_cfg.rise_limit == '0)
                            || (!w_gap_big && (48'(w_rise_lhs) >= w_rise_rhs)));

    assign w_tick    = (w_hot_ev || w_cold_ev) ? 8'd0 : r_span_tick;
    assign w_measure = w_sample && (w_tick != 8'd0) && !(w_tick < i_cfg.sample_span);
    assign w_cnt_inc = (w_fast && (r_rise_cnt != 8'hFF)) ? r_rise_cnt + 8'd1 : r_rise_cnt;
    assign w_rate_ev = w_measure && (w_cnt_inc > i_cfg.max_danger_count);

    assign w_clear = !w_sample && r_danger && i_item.button;

    always_comb begin
        n_danger     = r_danger;
        n_hot_dl     = r_hot_dl;
        n_cold_dl    = r_cold_dl;
        n_buzz_dl    = r_buzz_dl;
        n_span_tick  = r_span_tick;
        n_start_time = r_start_time;
        n_start_temp = r_start_temp;
        n_rise_cnt   = r_rise_cnt;
        if (w_sample) begin
            if (w_cold_ev) begin
                n_hot_dl  = w_now_recheck;
                n_cold_dl = w_now_hold;
            end else if (w_hot_ev) begin
                n_hot_dl  = w_now_hold;
                n_cold_dl = w_now_recheck;
            end else begin
                if (w_hot_exp) begin
                    n_hot_dl = w_now_recheck;
                end
                if (w_cold_exp) begin
                    n_cold_dl = w_now_recheck;
                end
            end
            if (w_tick == 8'd0) begin
                n_start_time = w_now;
                n_start_temp = i_item.temperature;
                n_span_tick  = 8'd1;
            end else if (w_tick < i_cfg.sample_span) begin
                n_span_tick = w_tick + 8'd1;
            end else begin
                n_span_tick = 8'd0;
                n_rise_cnt  = w_rate_ev ? 8'd0 : w_cnt_inc;
            end
            n_danger = r_danger || w_hot_ev || w_cold_ev || w_rate_ev;
        end else begin
            n_danger = r_danger && !w_clear;
            if (w_buzz_exp) begin
                n_buzz_dl = w_now_buzz;
            end
        end
    end

    always_comb begin
        o_result.fuse_off   = w_hot_ev || w_rate_ev;
        o_result.buzz       = !w_sample && w_buzz_exp && n_danger;
        o_result.in_danger  = n_danger;
        o_result.hot_event  = w_hot_ev;
        o_result.cold_event = w_cold_ev;
        o_result.rate_event = w_rate_ev;
        if (w_rate_ev || (w_hot_ev && !w_cold_ev)) begin
            o_result.message = MSG_DANGER;
        end else if (w_cold_ev) begin
            o_result.message = MSG_COLD;
        end else if (w_clear) begin
            o_result.message = MSG_CLEARED;
        end else begin
            o_result.message = MSG_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_danger     <= 1'b0;
            r_hot_dl     <= '0;
            r_cold_dl    <= '0;
            r_buzz_dl    <= TIME_BITS'(BUZZ_FIRST_MS);
            r_span_tick  <= 8'd0;
            r_start_time <= '0;
            r_start_temp <= 16'sd0;
            r_rise_cnt   <= 8'd0;
        end else if (i_advance) begin
            r_danger     <= n_danger;
            r_hot_dl     <= n_hot_dl;
            r_cold_dl    <= n_cold_dl;
            r_buzz_dl    <= n_buzz_dl;
            r_span_tick  <= n_span_tick;
            r_start_time <= n_start_time;
            r_start_temp <= n_start_temp;
            r_rise_cnt   <= n_rise_cnt;
        end
    end

endmodule

>>> rtl/thermal_alarm_monitor_unit.sv
// An item is captured in the input register; its result, computed by the step logic, is
// captured in the output register. The two-stage pipeline takes one item per cycle and
// advances whenever the output slot frees up, stalling while a result waits unaccepted.
// Reset (synchronous, active low) empties both stages, restores the register defaults,
// clears the alarm state and arms the first buzz for 4000 ms.
// ----------------------------------------------------------------------------
// thermal_alarm_monitor_unit
// Top level: input register, monitor engine, result register, config port.
// ----------------------------------------------------------------------------
module thermal_alarm_monitor_unit
    import tam_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tam_stream_if.sink   i_item,
    tam_stream_if.source o_result,
    tam_stream_if.sink   i_cfg
);

    t_cfg    w_cfg;
    t_result w_result;
    logic    w_advance;

    logic    r_in_vld;
    t_item   r_in;
    logic    r_out_vld;
    t_result r_out;

    assign w_advance     = r_in_vld && (!r_out_vld || o_result.ready);
    assign i_item.ready  = !r_in_vld || w_advance;
    assign o_result.valid = r_out_vld;
    assign o_result.data  = r_out;

    tam_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    tam_engine #(
        .TIME_BITS (TIME_BITS)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_advance (w_advance),
        .i_item    (r_in),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_item.valid && i_item.ready) begin
                r_in_vld <= 1'b1;
            end else if (w_advance) begin
                r_in_vld <= 1'b0;
            end
            if (w_advance) begin
                r_out_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in <= i_item.data;
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

endmodule
